/* rtl/binary_to_editable_text_top_defines.svh */
// Assertion macros shared by the checker files.
// Depends on nothing; include it by its bare file name.
`ifndef BINARY_TO_EDITABLE_TEXT_TOP_DEFINES_SVH
`define BINARY_TO_EDITABLE_TEXT_TOP_DEFINES_SVH

// Implication in the same cycle, off while reset is high.
`define BTE_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("binary_to_editable_text check failed");

// Implication in the next cycle, off while reset is high.
`define BTE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("binary_to_editable_text check failed");

// Implication in the next cycle, checked through reset.
`define BTE_ASSERT_ALWAYS_NEXT(label, clk_s, ante, cons) \
  label: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("binary_to_editable_text check failed");

`endif

/* rtl/bte_pkg.sv */
// Shared types, constants and the byte rendering function.
// Used by every module of the binary-to-text block; depends on nothing.
`default_nettype none

package bte_pkg;

  localparam int COL_W       = 18;
  localparam int LINE_W      = 17;
  localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

  localparam int TEXT_MAX    = 7;
  localparam int LEN_W       = $clog2(TEXT_MAX + 1);
  localparam int SEQ_MAX     = TEXT_MAX + 2;
  localparam int SEQ_W       = $clog2(SEQ_MAX + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LENGTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_LINES      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRAPHICS_MODE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_PRINTABLES = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_CONTROLS   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_FORMAT   = 3'd5;

  // graphics modes
  localparam logic [1:0] GFX_ESC       = 2'd1;
  localparam logic [1:0] GFX_BACKSLASH = 2'd2;

  // number formats; six and seven fall back to long hex
  localparam logic [2:0] FMT_LONG_HEX  = 3'd0;
  localparam logic [2:0] FMT_SHORT_HEX = 3'd1;
  localparam logic [2:0] FMT_LONG_DEC  = 3'd2;
  localparam logic [2:0] FMT_SHORT_DEC = 3'd3;
  localparam logic [2:0] FMT_LONG_OCT  = 3'd4;
  localparam logic [2:0] FMT_SHORT_OCT = 3'd5;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_GS    = 8'h1D;
  localparam logic [7:0] CH_US    = 8'h1F;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_LB    = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RB    = 8'h5D;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam int NAME_COUNT = 39;
  localparam logic [5:0] NAME_IDX_LB  = 6'd34;
  localparam logic [5:0] NAME_IDX_RB  = 6'd36;
  localparam logic [5:0] NAME_IDX_DEL = 6'd38;
  localparam logic [8*NAME_COUNT-1:0] NAME1 = "NSSEEEABBHLVFCSSDDDDDNSECESEFGRUS.L.R.D";
  localparam logic [8*NAME_COUNT-1:0] NAME2 = "UOTTONCESTFTFROILCCCCAYTAMUSSSSSP.B.B.E";
  localparam logic [8*NAME_COUNT-1:0] NAME3 = "LHXXTQKL        E1234KNBN BC     . . .L";

  typedef logic [TEXT_MAX-1:0][7:0] text_t;

  typedef struct packed {
    logic             nl;
    logic             ff;
    logic [LEN_W-1:0] len;
    text_t            text;
  } desc_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    text_t            text;
  } render_t;

  function automatic logic [7:0] name_pick(input logic [8*NAME_COUNT-1:0] tbl,
                                           input logic [5:0] idx);
    return tbl[8*(NAME_COUNT - 1 - int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + {4'b0, d}) : (8'h37 + {4'b0, d});
  endfunction

  // Text form of one byte: a name, the byte itself, or a numeric code.
  function automatic render_t render(input logic [7:0] b, input logic code_printables,
                                     input logic code_controls, input logic [2:0] fmt);
    render_t     r;
    logic        ctrl;
    logic        numeric;
    logic [5:0]  idx;
    logic [7:0]  n3;
    logic [1:0]  hund;
    logic [7:0]  rem8;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units7;
    logic [3:0]  units;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [3:0]  o2;
    logic [3:0]  o1;
    logic [3:0]  o0;
    r       = '0;
    ctrl    = (b <= CH_SP) || (b == CH_LB) || (b == CH_RB) || (b == CH_DEL);
    numeric = b[7] || (ctrl ? code_controls : code_printables);
    hi      = b[7:4];
    lo      = b[3:0];
    o2      = {2'b0, b[7:6]};
    o1      = {1'b0, b[5:3]};
    o0      = {1'b0, b[2:0]};
    hund    = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
    rem8    = b - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
    // divide by ten through the reciprocal, exact below 100
    prod    = {8'b0, rem8[6:0]} * 15'd205;
    tens    = prod[14:11];
    units7  = rem8[6:0] - {tens, 3'b0} - {2'b0, tens, 1'b0};
    units   = units7[3:0];
    idx     = (b == CH_LB) ? NAME_IDX_LB : ((b == CH_RB) ? NAME_IDX_RB :
              ((b == CH_DEL) ? NAME_IDX_DEL : b[5:0]));
    n3      = name_pick(NAME3, idx);
    if (!numeric && !ctrl) begin
      r.text[0] = b;
      r.len     = 3'd1;
    end else if (!numeric) begin
      r.text[0] = "[";
      r.text[1] = name_pick(NAME1, idx);
      r.text[2] = name_pick(NAME2, idx);
      if (n3 != " ") begin
        r.text[3] = n3;
        r.text[4] = "]";
        r.len     = 3'd5;
      end else begin
        r.text[3] = "]";
        r.len     = 3'd4;
      end
    end else begin
      r.text[0] = "[";
      case (fmt)
        FMT_SHORT_HEX: begin
          r.text[1] = "0";
          r.text[2] = "x";
          if (hi != 4'd0) begin
            r.text[3] = digit_char(hi);
            r.text[4] = digit_char(lo);
            r.text[5] = "]";
            r.len     = 3'd6;
          end else begin
            r.text[3] = digit_char(lo);
            r.text[4] = "]";
            r.len     = 3'd5;
          end
        end
        FMT_LONG_DEC: begin
          r.text[1] = "0";
          r.text[2] = "d";
          r.text[3] = digit_char({2'b0, hund});
          r.text[4] = digit_char(tens);
          r.text[5] = digit_char(units);
          r.text[6] = "]";
          r.len     = 3'd7;
        end
        FMT_SHORT_DEC: begin
          if (hund != 2'd0) begin
            r.text[1] = digit_char({2'b0, hund});
            r.text[2] = digit_char(tens);
            r.text[3] = digit_char(units);
            r.text[4] = "]";
            r.len     = 3'd5;
          end else if (tens != 4'd0) begin
            r.text[1] = digit_char(tens);
            r.text[2] = digit_char(units);
            r.text[3] = "]";
            r.len     = 3'd4;
          end else begin
            r.text[1] = digit_char(units);
            r.text[2] = "]";
            r.len     = 3'd3;
          end
        end
        FMT_LONG_OCT: begin
          r.text[1] = "0";
          r.text[2] = "o";
          r.text[3] = digit_char(o2);
          r.text[4] = digit_char(o1);
          r.text[5] = digit_char(o0);
          r.text[6] = "]";
          r.len     = 3'd7;
        end
        FMT_SHORT_OCT: begin
          r.text[1] = "0";
          if (o2 != 4'd0) begin
            r.text[2] = digit_char(o2);
            r.text[3] = digit_char(o1);
            r.text[4] = digit_char(o0);
            r.text[5] = "]";
            r.len     = 3'd6;
          end else if (o1 != 4'd0) begin
            r.text[2] = digit_char(o1);
            r.text[3] = digit_char(o0);
            r.text[4] = "]";
            r.len     = 3'd5;
          end else begin
            r.text[2] = digit_char(o0);
            r.text[3] = "]";
            r.len     = 3'd4;
          end
        end
        default: begin
          r.text[1] = "0";
          r.text[2] = "x";
          r.text[3] = digit_char(hi);
          r.text[4] = digit_char(lo);
          r.text[5] = "]";
          r.len     = 3'd6;
        end
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/bte_if.sv */
// Channel interfaces: input bytes, output characters, register writes.
// Depends on bte_pkg for the configuration widths.
`default_nettype none

interface bte_feed_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface bte_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

interface bte_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bte_pkg::CFG_INDEX_W-1:0]  index;
  logic [bte_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/bte_front.sv */
// Front end: registers, column and line counters, byte rendering.
// Depends on bte_pkg and bte_if; feeds descriptors to bte_queue.
`default_nettype none

module bte_front (
  input  wire logic           clk,
  input  wire logic           rst,
  bte_feed_if.sink            feed,
  bte_cfg_if.sink             cfg,
  input  wire bte_pkg::qstat_t qstat,
  output logic                push,
  output bte_pkg::desc_t      entry
);

  logic [15:0] line_length;
  logic [15:0] page_lines;
  logic [1:0]  graphics_mode;
  logic        code_printables;
  logic        code_controls;
  logic [2:0]  number_format;

  logic [bte_pkg::COL_W-1:0]  column_count;
  logic [bte_pkg::COL_W-1:0]  column_count_next;
  logic [bte_pkg::LINE_W-1:0] line_count;
  logic [bte_pkg::LINE_W-1:0] line_count_next;

  bte_pkg::render_t           rend;
  logic                       gfx_break;
  logic [bte_pkg::COL_W:0]    sum1;
  logic [bte_pkg::COL_W:0]    sum2;
  logic [bte_pkg::COL_W-1:0]  col1;
  logic [bte_pkg::COL_W-1:0]  col2;
  logic [bte_pkg::LINE_W-1:0] line1;
  logic                       wrap;
  logic                       page;

  assign cfg.ready  = 1'b1;
  assign feed.ready = !qstat.full;
  assign push       = feed.valid && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= 16'd72;
      page_lines      <= 16'd0;
      graphics_mode   <= 2'd0;
      code_printables <= 1'b0;
      code_controls   <= 1'b0;
      number_format   <= 3'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        bte_pkg::CFG_LINE_LENGTH:     line_length     <= cfg.data;
        bte_pkg::CFG_PAGE_LINES:      page_lines      <= cfg.data;
        bte_pkg::CFG_GRAPHICS_MODE:   graphics_mode   <= cfg.data[1:0];
        bte_pkg::CFG_CODE_PRINTABLES: code_printables <= cfg.data[0];
        bte_pkg::CFG_CODE_CONTROLS:   code_controls   <= cfg.data[0];
        bte_pkg::CFG_NUMBER_FORMAT:   number_format   <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rend      = bte_pkg::render(feed.data_byte, code_printables, code_controls,
                                number_format);
    gfx_break = ((graphics_mode == bte_pkg::GFX_ESC) &&
                 ((feed.data_byte == bte_pkg::CH_ESC) || (feed.data_byte == bte_pkg::CH_GS) ||
                  (feed.data_byte == bte_pkg::CH_US))) ||
                ((graphics_mode == bte_pkg::GFX_BACKSLASH) &&
                 (feed.data_byte == bte_pkg::CH_BSL));
    // saturating adds on the column count
    sum1 = {1'b0, column_count} + {3'b0, line_length};
    col1 = gfx_break ? (sum1[bte_pkg::COL_W] ? bte_pkg::COL_MAX : sum1[bte_pkg::COL_W-1:0])
                     : column_count;
    sum2 = {1'b0, col1} + {{(bte_pkg::COL_W + 1 - bte_pkg::LEN_W){1'b0}}, rend.len};
    col2 = sum2[bte_pkg::COL_W] ? bte_pkg::COL_MAX : sum2[bte_pkg::COL_W-1:0];
    wrap = (line_length != 16'd0) && ({2'b0, line_length} < col2);
    line1 = (line_count < bte_pkg::LINE_MAX) ? (line_count + 17'd1) : line_count;
    page = wrap && (page_lines != 16'd0) && ({1'b0, page_lines} < line1);

    column_count_next = column_count;
    line_count_next   = line_count;
    entry             = '0;
    if (feed.func) begin
      column_count_next = '0;
      line_count_next   = 17'd1;
      entry.nl          = 1'b1;
    end else begin
      entry.nl   = wrap;
      entry.ff   = page;
      entry.len  = rend.len;
      entry.text = rend.text;
      if (page) begin
        column_count_next = {{(bte_pkg::COL_W - bte_pkg::LEN_W){1'b0}}, rend.len} + 18'd1;
        line_count_next   = 17'd1;
      end else if (wrap) begin
        column_count_next = {{(bte_pkg::COL_W - bte_pkg::LEN_W){1'b0}}, rend.len};
        line_count_next   = line1;
      end else begin
        column_count_next = col2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      line_count   <= 17'd1;
    end else if (push) begin
      column_count <= column_count_next;
      line_count   <= line_count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/bte_queue.sv */
// Short descriptor queue between the front and back ends.
// Depends on bte_pkg.
`default_nettype none

module bte_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bte_pkg::desc_t  entry,
  input  wire logic            pop,
  output bte_pkg::desc_t       head,
  output bte_pkg::qstat_t      qstat
);

  bte_pkg::desc_t              slots [bte_pkg::QUEUE_DEPTH];
  logic [bte_pkg::QPTR_W-1:0]  wr_ptr;
  logic [bte_pkg::QPTR_W-1:0]  rd_ptr;
  logic [bte_pkg::QCNT_W-1:0]  count;

  assign head            = slots[rd_ptr];
  assign qstat.not_empty = (count != '0);
  assign qstat.full      = (count == bte_pkg::QCNT_W'(bte_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/bte_back.sv */
// Back end: walks the head descriptor one character a cycle into the output register while the receiver is ready.
// Depends on bte_pkg and bte_if; pops bte_queue.
`default_nettype none

module bte_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bte_pkg::desc_t  head,
  input  wire bte_pkg::qstat_t qstat,
  output logic                 pop,
  bte_text_if.source           text
);

  logic [bte_pkg::SEQ_W-1:0] pos;
  logic [bte_pkg::SEQ_W-1:0] total;
  logic [bte_pkg::SEQ_W-1:0] offset;
  logic [bte_pkg::SEQ_W-1:0] tpos;
  logic                      load;
  logic                      at_end;
  logic [7:0]                ch;

  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;

  assign text.valid    = out_valid;
  assign text.out_char = out_char;
  assign text.last     = out_last;

  always_comb begin
    offset = {{(bte_pkg::SEQ_W - 1){1'b0}}, head.nl} + {{(bte_pkg::SEQ_W - 1){1'b0}}, head.ff};
    total  = offset + {{(bte_pkg::SEQ_W - bte_pkg::LEN_W){1'b0}}, head.len};
    tpos   = pos - offset;
    load   = qstat.not_empty && (!out_valid || text.ready);
    at_end = (pos == total - 1'b1);
    pop    = load && at_end;
    if (pos < {{(bte_pkg::SEQ_W - 1){1'b0}}, head.nl}) begin
      ch = bte_pkg::CH_LF;
    end else if (pos < offset) begin
      ch = bte_pkg::CH_FF;
    end else begin
      ch = head.text[tpos[bte_pkg::LEN_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= ch;
      out_last <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= at_end ? '0 : (pos + 1'b1);
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/binary_to_editable_text_top.sv */
// Top level of the binary-to-editable-text converter.
// Depends on bte_pkg, bte_if, bte_front, bte_queue and bte_back.
//
// Turns a stream of raw bytes into editable text, one character per output
// word, with last set on the final character each input word causes. A data
// word (func 0) yields one to seven text characters, preceded by a newline
// and possibly a form feed when the line or page would overflow, so one to
// nine output words in all; an end word (func 1) yields a lone newline and
// resets the column and line counts. The front end takes an input word in
// every cycle that the four-entry descriptor queue has room, and the output
// register emits one character per cycle while the receiver is ready, so the
// character sequencer sets the sustained rate. The first character of a word
// passes through the descriptor queue and then the output register.
// Registers are written through the cfg channel, which is always ready;
// write them only while no output is still pending.
`default_nettype none

module binary_to_editable_text_top (
  input  wire logic   clk,
  input  wire logic   rst,
  bte_feed_if.sink    feed,
  bte_cfg_if.sink     cfg,
  bte_text_if.source  text
);

  // descriptor handed from the front end to the queue
  bte_pkg::desc_t  entry;
  bte_pkg::desc_t  head;
  bte_pkg::qstat_t qstat;
  logic            push;
  logic            pop;

  // Classify and count: one word per cycle while the queue has room.
  bte_front u_front (
    .clk   (clk),
    .rst   (rst),
    .feed  (feed),
    .cfg   (cfg),
    .qstat (qstat),
    .push  (push),
    .entry (entry)
  );

  // Hold up to four pending words so either side can stall alone.
  bte_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Emit characters; drop the head once its last character is registered.
  bte_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .text  (text)
  );

endmodule

`default_nettype wire

/* rtl/bte_checker.sv */
// Port-level checks on the converter's output stream, bound to the top level.
// Depends on bte_pkg and binary_to_editable_text_top_defines.svh.
`default_nettype none
`include "binary_to_editable_text_top_defines.svh"

module bte_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       text_valid,
  input wire logic       text_ready,
  input wire logic [7:0] out_char,
  input wire logic       last
);

  logic [7:0] prev_char;

  // hold the last character delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_char <= '0;
    end else if (text_valid && text_ready) begin
      prev_char <= out_char;
    end
  end

  `BTE_ASSERT_ALWAYS_NEXT(a_reset_idle, clk, rst, !text_valid)
  `BTE_ASSERT_NEXT(a_stall_hold, clk, rst, text_valid && !text_ready, text_valid && $stable(out_char) && $stable(last))
  `BTE_ASSERT_NOW(a_ff_after_nl, clk, rst, text_valid && text_ready && (out_char == bte_pkg::CH_FF), prev_char == bte_pkg::CH_LF)
  `BTE_ASSERT_NOW(a_last_char, clk, rst, text_valid && last, (out_char != bte_pkg::CH_FF) && (out_char != bte_pkg::CH_LB))

endmodule

bind binary_to_editable_text_top bte_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .text_valid (text.valid),
  .text_ready (text.ready),
  .out_char   (text.out_char),
  .last       (text.last)
);

`default_nettype wire

/* dv/tb_binary_to_editable_text_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for binary_to_editable_text_top: byte feed, text checks.
// Depends on bte_pkg and the bte_if channel interfaces of the RTL.
`default_nettype none

module tb_binary_to_editable_text_top;

  // word kinds on the feed channel
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // codes outside the documented ranges; the block must fall back or ignore them
  localparam logic [bte_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 3'd6;
  localparam logic [1:0]                      GFX_UNUSED = 2'd3;
  localparam logic [2:0]                      FMT_UNUSED = 3'd7;
  localparam logic [1:0]                      GFX_NONE   = 2'd0;

  localparam int RANDOM_PHASES   = 10;
  localparam int WORDS_PER_PHASE = 39;
  localparam int HOLD_CYCLES     = 300;
  localparam int TAIL_CYCLES     = 12;

  // one expected output character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_word_t;

  // Predicts the text a stream of bytes turns into and checks the block against it.
  class text_scoreboard;
    logic [15:0] line_length;
    logic [15:0] page_lines;
    logic [1:0]  gfx_mode;
    logic        code_printables;
    logic        code_controls;
    logic [2:0]  num_format;
    int unsigned column;
    int unsigned line;
    text_word_t  expected_chars[$];
    byte unsigned glyphs[$];
    int          errors;
    int          words_in;
    int          chars_out;
    string       name_row1 = "NSSEEEABBHLVFCSSDDDDDNSECESEFGRUS.L.R.D";
    string       name_row2 = "UOTTONCESTFTFROILCCCCAYTAMUSSSSSP.B.B.E";
    string       name_row3 = "LHXXTQKL        E1234KNBN BC     . . .L";
    string       digit_set = "0123456789ABCDEF";

    function new();
      line_length     = 16'd72;
      page_lines      = 16'd0;
      gfx_mode        = GFX_NONE;
      code_printables = 1'b0;
      code_controls   = 1'b0;
      num_format      = bte_pkg::FMT_LONG_HEX;
      column          = 0;
      line            = 1;
      errors          = 0;
      words_in        = 0;
      chars_out       = 0;
    endfunction

    function void write_reg(logic [bte_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
      case (idx)
        bte_pkg::CFG_LINE_LENGTH:     line_length     = val;
        bte_pkg::CFG_PAGE_LINES:      page_lines      = val;
        bte_pkg::CFG_GRAPHICS_MODE:   gfx_mode        = val[1:0];
        bte_pkg::CFG_CODE_PRINTABLES: code_printables = val[0];
        bte_pkg::CFG_CODE_CONTROLS:   code_controls   = val[0];
        bte_pkg::CFG_NUMBER_FORMAT:   num_format      = val[2:0];
        default: ;
      endcase
    endfunction

    function void add_digits(int unsigned v, int unsigned base, int min_digits);
      byte unsigned tmp[$];
      do begin
        tmp.push_front(digit_set[v % base]);
        v = v / base;
      end while (v != 0);
      while (tmp.size() < min_digits) tmp.push_front("0");
      foreach (tmp[i]) glyphs.push_back(tmp[i]);
    endfunction

    // text form of one byte into glyphs
    function void render(logic [7:0] b);
      logic is_ctrl;
      logic numeric;
      int   slot;
      glyphs.delete();
      is_ctrl = (b <= bte_pkg::CH_SP) || (b == bte_pkg::CH_LB) || (b == bte_pkg::CH_RB) ||
                (b == bte_pkg::CH_DEL);
      numeric = (b > bte_pkg::CH_DEL) || (is_ctrl ? code_controls : code_printables);
      if (!numeric && !is_ctrl) begin
        glyphs.push_back(b);
      end else if (!numeric) begin
        slot = (b == bte_pkg::CH_LB)  ? int'(bte_pkg::NAME_IDX_LB) :
               (b == bte_pkg::CH_RB)  ? int'(bte_pkg::NAME_IDX_RB) :
               (b == bte_pkg::CH_DEL) ? int'(bte_pkg::NAME_IDX_DEL) : int'(b);
        glyphs.push_back("[");
        glyphs.push_back(name_row1[slot]);
        glyphs.push_back(name_row2[slot]);
        if (name_row3[slot] != " ") glyphs.push_back(name_row3[slot]);
        glyphs.push_back("]");
      end else begin
        glyphs.push_back("[");
        case (num_format)
          bte_pkg::FMT_SHORT_HEX: begin
            glyphs.push_back("0");
            glyphs.push_back("x");
            add_digits(b, 16, 1);
          end
          bte_pkg::FMT_LONG_DEC: begin
            glyphs.push_back("0");
            glyphs.push_back("d");
            add_digits(b, 10, 3);
          end
          bte_pkg::FMT_SHORT_DEC: add_digits(b, 10, 1);
          bte_pkg::FMT_LONG_OCT: begin
            glyphs.push_back("0");
            glyphs.push_back("o");
            add_digits(b, 8, 3);
          end
          bte_pkg::FMT_SHORT_OCT: begin
            glyphs.push_back("0");
            add_digits(b, 8, 1);
          end
          default: begin
            glyphs.push_back("0");
            glyphs.push_back("x");
            add_digits(b, 16, 2);
          end
        endcase
        glyphs.push_back("]");
      end
    endfunction

    function int unsigned col_sat(int unsigned v);
      return (v > bte_pkg::COL_MAX) ? int'(bte_pkg::COL_MAX) : v;
    endfunction

    // note an accepted feed word and queue the characters it must produce
    function void note_word(logic func, logic [7:0] b);
      byte unsigned seq[$];
      logic         breaker;
      words_in++;
      if (func == FUNC_END) begin
        expected_chars.push_back('{ch: bte_pkg::CH_LF, last: 1'b1});
        column = 0;
        line   = 1;
        return;
      end
      breaker = (gfx_mode == bte_pkg::GFX_ESC &&
                 (b == bte_pkg::CH_ESC || b == bte_pkg::CH_GS || b == bte_pkg::CH_US)) ||
                (gfx_mode == bte_pkg::GFX_BACKSLASH && b == bte_pkg::CH_BSL);
      if (breaker) column = col_sat(column + line_length);
      render(b);
      column = col_sat(column + glyphs.size());
      if (line_length != 0 && line_length < column) begin
        column = glyphs.size();
        if (line < bte_pkg::LINE_MAX) line++;
        seq.push_back(bte_pkg::CH_LF);
        if (page_lines != 0 && page_lines < line) begin
          column = col_sat(column + 1);
          line   = 1;
          seq.push_back(bte_pkg::CH_FF);
        end
      end
      foreach (glyphs[i]) seq.push_back(glyphs[i]);
      foreach (seq[i]) expected_chars.push_back('{ch: seq[i], last: (i == seq.size() - 1)});
    endfunction

    function void fail_note(string what, logic [7:0] exp_v, logic [7:0] act_v);
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
    endfunction

    // compare one accepted output character with the oldest expectation
    function void check_char(logic [7:0] ch, logic last);
      text_word_t e;
      chars_out++;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $time, ch, last);
        return;
      end
      e = expected_chars.pop_front();
      if (e.ch !== ch) fail_note("out_char", e.ch, ch);
      if (e.last !== last) fail_note("last", {7'b0, e.last}, {7'b0, last});
    endfunction
  endclass

  // directed bytes: every name class, both ends of the byte range
  localparam logic [7:0] PLAIN_BYTES [10] =
    '{8'h00, 8'h20, 8'h41, 8'h5B, 8'h5D, 8'h7F, 8'h80, 8'hFF, 8'h7E, 8'h0A};
  // graphics breakers and a few others under tight wrapping and paging
  localparam logic [7:0] BREAK_BYTES [6] =
    '{8'h1B, 8'h1D, 8'h1F, 8'h0F, 8'h41, 8'hFF};

  logic clk;
  logic rst;
  logic feed_idle_on;
  logic sink_idle_on;
  int   hold_request;
  int   settings_seen;
  text_scoreboard sb;

  bte_feed_if feed_ch ();
  bte_cfg_if  cfg_ch ();
  bte_text_if text_ch ();

  binary_to_editable_text_top dut (
    .clk  (clk),
    .rst  (rst),
    .feed (feed_ch),
    .cfg  (cfg_ch),
    .text (text_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Offer one word at the falling edge and hold it until the block takes it.
  // Idle cycles go in front at random so gaps land on every phase of the work.
  task automatic offer_word(input logic func, input logic [7:0] b);
    @(negedge clk);
    while (feed_idle_on && $urandom_range(99) < 9) begin
      feed_ch.valid = 1'b0;
      @(negedge clk);
    end
    feed_ch.valid     = 1'b1;
    feed_ch.func      = func;
    feed_ch.data_byte = b;
    @(posedge clk);
    while (!feed_ch.ready) @(posedge clk);
    sb.note_word(func, b);
  endtask

  // Drop valid after the last word of a burst.
  task automatic park_feed();
    @(negedge clk);
    feed_ch.valid = 1'b0;
  endtask

  // Write one register and mirror it in the predictor once the write is taken.
  task automatic write_reg(input logic [bte_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Hold the sender until every predicted character has come out.
  task automatic wait_text_drained();
    while (sb.expected_chars.size() != 0) @(posedge clk);
  endtask

  // Pick a line length or page size: mostly small, so wraps and form feeds
  // come often, with the extremes mixed in.
  function automatic logic [15:0] pick_span(input int lo_small, input int hi_small);
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(hi_small, lo_small));
    endcase
  endfunction

  // Random byte, weighted toward the cases the block treats specially.
  function automatic logic [7:0] pick_byte();
    logic [7:0] breakers [4];
    logic [7:0] oddballs [6];
    breakers = '{bte_pkg::CH_ESC, bte_pkg::CH_GS, bte_pkg::CH_US, bte_pkg::CH_BSL};
    oddballs = '{bte_pkg::CH_LB, bte_pkg::CH_RB, bte_pkg::CH_DEL, bte_pkg::CH_SP,
                 8'h00, 8'hFF};
    case ($urandom_range(19))
      0, 1, 2: return breakers[$urandom_range(3)];
      3, 4:    return oddballs[$urandom_range(5)];
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Receiver: ready changes at the falling edge. A hold request from the
  // stimulus is counted down here, so the sender keeps offering words while
  // the block backs up and stalls its input.
  initial begin
    int stall_left;
    stall_left    = 0;
    text_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        text_ch.ready = 1'b0;
        stall_left--;
      end else begin
        text_ch.ready = !(sink_idle_on && $urandom_range(99) < 9);
      end
    end
  end

  // Sample the output side at the rising edge; every taken word is checked.
  always @(posedge clk) begin
    if (!rst && text_ch.valid && text_ch.ready)
      sb.check_char(text_ch.out_char, text_ch.last);
  end

  // Main stimulus.
  initial begin
    logic [7:0] b;
    sb                = new();
    rst               = 1'b1;
    feed_idle_on      = 1'b1;
    sink_idle_on      = 1'b1;
    hold_request      = 0;
    settings_seen     = 1;
    feed_ch.valid     = 1'b0;
    feed_ch.func      = FUNC_DATA;
    feed_ch.data_byte = 8'h00;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = bte_pkg::CFG_LINE_LENGTH;
    cfg_ch.data       = 16'h0000;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: names, pass-through, default long hex, then an end word
    // carrying a nonzero byte that must be ignored.
    foreach (PLAIN_BYTES[i]) offer_word(FUNC_DATA, PLAIN_BYTES[i]);
    offer_word(FUNC_END, 8'hA5);
    park_feed();
    wait_text_drained();

    // Tight lines and two-line pages with every byte coded in short hex;
    // the escape breakers force a newline ahead of their text.
    write_reg(bte_pkg::CFG_LINE_LENGTH, 16'd5);
    write_reg(bte_pkg::CFG_PAGE_LINES, 16'd2);
    write_reg(bte_pkg::CFG_GRAPHICS_MODE, {14'b0, bte_pkg::GFX_ESC});
    write_reg(bte_pkg::CFG_CODE_PRINTABLES, 16'd1);
    write_reg(bte_pkg::CFG_CODE_CONTROLS, 16'd1);
    write_reg(bte_pkg::CFG_NUMBER_FORMAT, {13'b0, bte_pkg::FMT_SHORT_HEX});
    settings_seen++;
    foreach (BREAK_BYTES[i]) offer_word(FUNC_DATA, BREAK_BYTES[i]);
    park_feed();
    wait_text_drained();

    // Wrapping off: a backslash breaker adds nothing. The spare format code
    // falls back to long hex; a write to the spare index changes nothing.
    write_reg(bte_pkg::CFG_LINE_LENGTH, 16'd0);
    write_reg(bte_pkg::CFG_GRAPHICS_MODE, {14'b0, bte_pkg::GFX_BACKSLASH});
    write_reg(bte_pkg::CFG_NUMBER_FORMAT, {13'b0, FMT_UNUSED});
    write_reg(CFG_UNUSED, 16'hFFFF);
    settings_seen++;
    offer_word(FUNC_DATA, bte_pkg::CH_BSL);
    offer_word(FUNC_DATA, 8'hC8);
    park_feed();
    wait_text_drained();

    // Widest line: the spare graphics mode does not break, backslash mode does.
    write_reg(bte_pkg::CFG_LINE_LENGTH, 16'hFFFF);
    write_reg(bte_pkg::CFG_GRAPHICS_MODE, {14'b0, GFX_UNUSED});
    offer_word(FUNC_DATA, bte_pkg::CH_BSL);
    park_feed();
    wait_text_drained();
    write_reg(bte_pkg::CFG_GRAPHICS_MODE, {14'b0, bte_pkg::GFX_BACKSLASH});
    settings_seen++;
    offer_word(FUNC_DATA, bte_pkg::CH_BSL);
    offer_word(FUNC_END, 8'h00);
    park_feed();
    wait_text_drained();

    // The column and line counts saturate far above any limit a register can
    // hold, so saturation cannot change a character; it is not driven here.

    // Random phases: fresh settings each time, written only once the block
    // has drained, then a burst of random words with end words scattered in.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(bte_pkg::CFG_LINE_LENGTH, pick_span(3, 24));
      write_reg(bte_pkg::CFG_PAGE_LINES, pick_span(1, 6));
      write_reg(bte_pkg::CFG_GRAPHICS_MODE, 16'($urandom_range(16'hFFFF)));
      write_reg(bte_pkg::CFG_CODE_PRINTABLES, 16'($urandom_range(16'hFFFF)));
      write_reg(bte_pkg::CFG_CODE_CONTROLS, 16'($urandom_range(16'hFFFF)));
      write_reg(bte_pkg::CFG_NUMBER_FORMAT, 16'($urandom_range(16'hFFFF)));
      settings_seen++;

      // one phase runs flat out on both sides
      feed_idle_on = (phase != 2);
      sink_idle_on = (phase != 2);
      // in another the receiver stops for a long stretch while words keep coming
      if (phase == 4) hold_request = HOLD_CYCLES;

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        b = pick_byte();
        if ($urandom_range(19) == 0) offer_word(FUNC_END, b);
        else offer_word(FUNC_DATA, b);
      end
      park_feed();
      wait_text_drained();
    end

    feed_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.expected_chars.size() != 0) begin
      sb.errors += sb.expected_chars.size();
      $display("%0t: %0d expected characters never arrived", $time,
               sb.expected_chars.size());
    end
    $display("Run covered %0d feed words and %0d text characters over %0d settings,",
             sb.words_in, sb.chars_out, settings_seen);
    $display("including a %0d-cycle output stall and a no-idle phase; %0d errors.",
             HOLD_CYCLES, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_binary_to_editable_text_top: done, clean");
    end else begin
      $display("tb_binary_to_editable_text_top: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("tb_binary_to_editable_text_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
